/* design/triangle_tangent_calc_assert.svh */
// ----------------------------------------------------------------------------
// triangle tangent assertion macros
// helpers for the concurrent checks in the ttc_ctrl design module
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_CALC_ASSERT_SVH
`define TRIANGLE_TANGENT_CALC_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ttc_pkg.sv */
// ----------------------------------------------------------------------------
// ttc_pkg
// widths, codes and the controller/datapath interface types of the tangent block
// ----------------------------------------------------------------------------
package ttc_pkg;

	localparam int COORD_W       = 32;              // Q16.16 port fields
	localparam int DIFF_W        = COORD_W + 1;     // corner differences
	localparam int PROD_W        = 2 * DIFF_W;      // one product
	localparam int WIDE_W        = PROD_W + 1;      // difference of two products
	localparam int QUOT_W        = COORD_W;         // quotient bits resolved
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [QUOT_W-1:0] SAT_POS = {1'b0, {(QUOT_W-1){1'b1}}};
	localparam logic [QUOT_W-1:0] SAT_NEG = {1'b1, {(QUOT_W-1){1'b0}}};

	// operand pairs of the shared multiplier
	typedef enum logic [2:0] {
		MS_DU1_DV2,
		MS_DU2_DV1,
		MS_E1X_DV2,
		MS_E2X_DV1,
		MS_E1Y_DV2,
		MS_E2Y_DV1,
		MS_E1Z_DV2,
		MS_E2Z_DV1
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [1:0] {
		CMP_X,
		CMP_Y,
		CMP_Z
	} comp_t;

	typedef struct packed {
		logic     hold_en;     // store corner 0 or 1
		logic     hold_slot;
		logic     capture;     // third corner: latch the differences
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     r_load;      // determinant magnitude and sign
		logic     mag_load;    // numerator magnitude and result sign
		logic     n_load;      // scaled dividend
		logic     div_start;
		logic     div_step;
		logic     comp_store;
		comp_t    comp_idx;
		logic     out_load;
		logic     out_degen;
	} ttc_cmd_t;

	typedef struct packed {
		logic r_zero;
	} ttc_status_t;

	// sign-extended difference of two port fields
	function automatic logic signed [DIFF_W-1:0] sub_ext(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

endpackage

/* design/ttc_datapath.sv */
// ----------------------------------------------------------------------------
// ttc_datapath
// corner store, shared multiplier, accumulator and radix-2 divider with saturation
// ----------------------------------------------------------------------------
module ttc_datapath #(
	parameter int FRAC_BITS = ttc_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  ttc_pkg::ttc_cmd_t                  cmd,
	output ttc_pkg::ttc_status_t               status,
	input  logic signed [ttc_pkg::COORD_W-1:0] pos_x,
	input  logic signed [ttc_pkg::COORD_W-1:0] pos_y,
	input  logic signed [ttc_pkg::COORD_W-1:0] pos_z,
	input  logic signed [ttc_pkg::COORD_W-1:0] tex_u,
	input  logic signed [ttc_pkg::COORD_W-1:0] tex_v,
	output logic signed [ttc_pkg::COORD_W-1:0] tangent_x,
	output logic signed [ttc_pkg::COORD_W-1:0] tangent_y,
	output logic signed [ttc_pkg::COORD_W-1:0] tangent_z,
	output logic                               degenerate,
	output logic                               saturated
);
	import ttc_pkg::*;

	localparam int NUM_W = WIDE_W + FRAC_BITS + 2;   // |num| * 2^(F+1) + |r|
	localparam int TOP_W = NUM_W - QUOT_W;
	localparam int DEN_W = WIDE_W + 1;               // 2 * |r|

	logic signed [COORD_W-1:0] hp_q [2][3];
	logic signed [COORD_W-1:0] ht_q [2][2];
	logic signed [DIFF_W-1:0]  e1_q [3];
	logic signed [DIFF_W-1:0]  e2_q [3];
	logic signed [DIFF_W-1:0]  du1_q, du2_q, dv1_q, dv2_q;
	logic signed [DIFF_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [WIDE_W-1:0]  acc_q;
	logic [WIDE_W-1:0]         ar_q, an_q;
	logic                      r_neg_q, neg_q;
	logic [NUM_W-1:0]          n_q;
	logic [DEN_W-1:0]          den, rem_q, n_top;
	logic [DEN_W:0]            rem_shift, trial;
	logic [QUOT_W-1:0]         lo_q, q_q;
	logic                      presat_q, sat_q;
	logic [QUOT_W-1:0]         limit, mag;
	logic                      over;
	logic [COORD_W-1:0]        tx_q, ty_q, tz_q, comp_val;

	function automatic logic [WIDE_W-1:0] abs_wide(input logic signed [WIDE_W-1:0] v);
		return v[WIDE_W-1] ? -v : v;
	endfunction

	// corners 0 and 1, then differences from corner 0 on the third corner
	always_ff @(posedge clk) begin
		if (cmd.hold_en) begin
			hp_q[cmd.hold_slot][0] <= pos_x;
			hp_q[cmd.hold_slot][1] <= pos_y;
			hp_q[cmd.hold_slot][2] <= pos_z;
			ht_q[cmd.hold_slot][0] <= tex_u;
			ht_q[cmd.hold_slot][1] <= tex_v;
		end
		if (cmd.capture) begin
			e1_q[0] <= sub_ext(hp_q[1][0], hp_q[0][0]);
			e1_q[1] <= sub_ext(hp_q[1][1], hp_q[0][1]);
			e1_q[2] <= sub_ext(hp_q[1][2], hp_q[0][2]);
			e2_q[0] <= sub_ext(pos_x, hp_q[0][0]);
			e2_q[1] <= sub_ext(pos_y, hp_q[0][1]);
			e2_q[2] <= sub_ext(pos_z, hp_q[0][2]);
			du1_q   <= sub_ext(ht_q[1][0], ht_q[0][0]);
			dv1_q   <= sub_ext(ht_q[1][1], ht_q[0][1]);
			du2_q   <= sub_ext(tex_u, ht_q[0][0]);
			dv2_q   <= sub_ext(tex_v, ht_q[0][1]);
		end
	end

	// operand selection for the shared multiplier
	always_comb begin
		case (cmd.mul_sel)
			MS_DU1_DV2: begin mul_a = du1_q;   mul_b = dv2_q; end
			MS_DU2_DV1: begin mul_a = du2_q;   mul_b = dv1_q; end
			MS_E1X_DV2: begin mul_a = e1_q[0]; mul_b = dv2_q; end
			MS_E2X_DV1: begin mul_a = e2_q[0]; mul_b = dv1_q; end
			MS_E1Y_DV2: begin mul_a = e1_q[1]; mul_b = dv2_q; end
			MS_E2Y_DV1: begin mul_a = e2_q[1]; mul_b = dv1_q; end
			MS_E1Z_DV2: begin mul_a = e1_q[2]; mul_b = dv2_q; end
			MS_E2Z_DV1: begin mul_a = e2_q[2]; mul_b = dv1_q; end
			default:    begin mul_a = du1_q;   mul_b = dv2_q; end
		endcase
	end

	assign status.r_zero = (acc_q == '0);

	assign den       = {ar_q, 1'b0};
	assign n_top     = DEN_W'(n_q[NUM_W-1 -: TOP_W]);
	assign rem_shift = {rem_q, lo_q[QUOT_W-1]};
	assign trial     = rem_shift - {1'b0, den};

	assign limit    = neg_q ? SAT_NEG : SAT_POS;
	assign over     = presat_q || (q_q > limit);
	assign mag      = over ? limit : q_q;
	assign comp_val = neg_q ? -mag : mag;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= WIDE_W'(prod_q);
			ACC_SUB:  acc_q <= acc_q - WIDE_W'(prod_q);
			default:  acc_q <= acc_q;
		endcase
		if (cmd.r_load) begin
			ar_q    <= abs_wide(acc_q);
			r_neg_q <= acc_q[WIDE_W-1];
		end
		if (cmd.mag_load) begin
			an_q  <= abs_wide(acc_q);
			neg_q <= acc_q[WIDE_W-1] ^ r_neg_q;
		end
		if (cmd.n_load) begin
			n_q <= (NUM_W'(an_q) << (FRAC_BITS + 1)) + NUM_W'(ar_q);
		end
		// quotient of 2^32 or more can only saturate
		if (cmd.div_start) begin
			rem_q    <= n_top;
			lo_q     <= n_q[QUOT_W-1:0];
			presat_q <= (n_top >= den);
			q_q      <= '0;
		end else if (cmd.div_step) begin
			if (!trial[DEN_W]) begin
				rem_q <= trial[DEN_W-1:0];
			end else begin
				rem_q <= rem_shift[DEN_W-1:0];
			end
			lo_q <= {lo_q[QUOT_W-2:0], 1'b0};
			q_q  <= {q_q[QUOT_W-2:0], !trial[DEN_W]};
		end
		if (cmd.capture) begin
			sat_q <= 1'b0;
		end else if (cmd.comp_store) begin
			sat_q <= sat_q | over;
		end
		if (cmd.comp_store) begin
			case (cmd.comp_idx)
				CMP_X:   tx_q <= comp_val;
				CMP_Y:   ty_q <= comp_val;
				CMP_Z:   tz_q <= comp_val;
				default: tz_q <= comp_val;
			endcase
		end
		if (cmd.out_load) begin
			tangent_x  <= cmd.out_degen ? '0 : tx_q;
			tangent_y  <= cmd.out_degen ? '0 : ty_q;
			tangent_z  <= cmd.out_degen ? '0 : tz_q;
			degenerate <= cmd.out_degen;
			saturated  <= !cmd.out_degen && sat_q;
		end
	end

endmodule

/* design/ttc_ctrl.sv */
// ----------------------------------------------------------------------------
// ttc_ctrl
// corner counting, operation sequencing and output register handshake
// ----------------------------------------------------------------------------
`include "triangle_tangent_calc_assert.svh"

module ttc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ttc_pkg::ttc_cmd_t    cmd,
	input  ttc_pkg::ttc_status_t status
);
	import ttc_pkg::*;

	localparam int         CNT_W       = $clog2(QUOT_W);
	localparam logic [1:0] CORNER_LAST = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RA,
		S_RB,
		S_RC,
		S_RD,
		S_NA,
		S_NB,
		S_NC,
		S_DA,
		S_DN,
		S_DS,
		S_DIV,
		S_DF,
		S_OUT
	} state_t;

	state_t             state_q;
	logic [1:0]         corner_q;
	comp_t              comp_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               deg_q;
	logic               out_valid_q;
	logic               in_xfer;
	logic               out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.hold_slot = corner_q[0];
		cmd.comp_idx  = comp_q;
		cmd.out_degen = deg_q;
		case (state_q)
			S_IDLE: begin
				cmd.hold_en = in_xfer && (corner_q != CORNER_LAST);
				cmd.capture = in_xfer && (corner_q == CORNER_LAST);
			end
			S_RA: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_DU1_DV2;
			end
			S_RB: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_DU2_DV1;
				cmd.acc_op  = ACC_LOAD;
			end
			S_RC:  cmd.acc_op = ACC_SUB;
			S_RD:  cmd.r_load = 1'b1;
			S_NA: begin
				cmd.mul_en = 1'b1;
				case (comp_q)
					CMP_X:   cmd.mul_sel = MS_E1X_DV2;
					CMP_Y:   cmd.mul_sel = MS_E1Y_DV2;
					CMP_Z:   cmd.mul_sel = MS_E1Z_DV2;
					default: cmd.mul_sel = MS_E1Z_DV2;
				endcase
			end
			S_NB: begin
				cmd.mul_en = 1'b1;
				cmd.acc_op = ACC_LOAD;
				case (comp_q)
					CMP_X:   cmd.mul_sel = MS_E2X_DV1;
					CMP_Y:   cmd.mul_sel = MS_E2Y_DV1;
					CMP_Z:   cmd.mul_sel = MS_E2Z_DV1;
					default: cmd.mul_sel = MS_E2Z_DV1;
				endcase
			end
			S_NC:  cmd.acc_op     = ACC_SUB;
			S_DA:  cmd.mag_load   = 1'b1;
			S_DN:  cmd.n_load     = 1'b1;
			S_DS:  cmd.div_start  = 1'b1;
			S_DIV: cmd.div_step   = 1'b1;
			S_DF:  cmd.comp_store = 1'b1;
			S_OUT: cmd.out_load   = out_free;
			default: cmd.hold_en  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			corner_q    <= 2'd0;
			comp_q      <= CMP_X;
			cnt_q       <= '0;
			deg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (state_q == S_OUT && out_free) ? 1'b1 : (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (corner_q == CORNER_LAST) begin
							corner_q <= 2'd0;
							state_q  <= S_RA;
						end else begin
							corner_q <= corner_q + 2'd1;
						end
					end
				end
				S_RA: state_q <= S_RB;
				S_RB: state_q <= S_RC;
				S_RC: state_q <= S_RD;
				S_RD: begin
					// zero determinant skips the divisions
					deg_q  <= status.r_zero;
					comp_q <= CMP_X;
					state_q <= status.r_zero ? S_OUT : S_NA;
				end
				S_NA: state_q <= S_NB;
				S_NB: state_q <= S_NC;
				S_NC: state_q <= S_DA;
				S_DA: state_q <= S_DN;
				S_DN: state_q <= S_DS;
				S_DS: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUOT_W - 1)) begin
						state_q <= S_DF;
					end
				end
				S_DF: begin
					case (comp_q)
						CMP_X: begin
							comp_q  <= CMP_Y;
							state_q <= S_NA;
						end
						CMP_Y: begin
							comp_q  <= CMP_Z;
							state_q <= S_NA;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TTC_ASSERT_NOW(a_corner_clear_busy, clk, arst_n, state_q != S_IDLE, corner_q == 2'd0, "corner count not cleared during face work")
	`TTC_ASSERT_NOW(a_cnt_idle, clk, arst_n, state_q != S_DIV, cnt_q == '0, "divider step count left nonzero")
	`TTC_ASSERT_NOW(a_valid_from_out, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_OUT, "result shown outside the output step")
	`TTC_ASSERT_NEXT(a_degen_skip, clk, arst_n, state_q == S_RD && status.r_zero, state_q == S_OUT && deg_q, "zero determinant did not skip to output")

endmodule

/* design/triangle_tangent_calc.sv */
// ----------------------------------------------------------------------------
// triangle_tangent_calc
// unnormalised face tangent of a textured triangle, one corner per transfer
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  in       to block   in_valid / in_stall     pos_x pos_y pos_z tex_u tex_v
//  out      from block out_valid / out_stall   tangent_x tangent_y tangent_z
//                                              degenerate saturated
//
// corners 0 and 1 of a face are taken in one cycle each
// the third corner starts the work on a face; with a non-zero determinant it uses
// one shared 33x33 multiplier and a one-bit-per-cycle divider: the determinant r,
// then for each tangent component a numerator, a division and a store, then one
// output load; a zero determinant skips the divisions and goes to the output load
// arst_n clears the corner count, sequencer and output valid; held corners are
// undefined until written
// the result sits in an output register, so corners of the next face are taken
// while out_stall holds it; only the final load waits for that register
//
module triangle_tangent_calc #(
	parameter int FRAC_BITS = ttc_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [ttc_pkg::COORD_W-1:0] pos_x,
	input  logic signed [ttc_pkg::COORD_W-1:0] pos_y,
	input  logic signed [ttc_pkg::COORD_W-1:0] pos_z,
	input  logic signed [ttc_pkg::COORD_W-1:0] tex_u,
	input  logic signed [ttc_pkg::COORD_W-1:0] tex_v,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ttc_pkg::COORD_W-1:0] tangent_x,
	output logic signed [ttc_pkg::COORD_W-1:0] tangent_y,
	output logic signed [ttc_pkg::COORD_W-1:0] tangent_z,
	output logic                               degenerate,
	output logic                               saturated
);
	import ttc_pkg::*;

	// command and status between sequencer and datapath
	ttc_cmd_t    cmd;
	ttc_status_t status;

	// sequencer: corner count, per-component steps, divider count, out valid
	ttc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath: corner store, differences, multiplier, accumulator, divider,
	// rounding with ties away from zero, saturation and output register
	ttc_datapath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.status     (status),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.tex_u      (tex_u),
		.tex_v      (tex_v),
		.tangent_x  (tangent_x),
		.tangent_y  (tangent_y),
		.tangent_z  (tangent_z),
		.degenerate (degenerate),
		.saturated  (saturated)
	);

endmodule
